FILE: rtl/core/scrld_pkg.sv
// ----------------------------------------------------------------------------
// scrld_pkg: shared definitions for the sprite cell run-length decoder
// Result kinds, history store sizing and the pattern color step table.
// ----------------------------------------------------------------------------
package scrld_pkg;

    localparam int CELL_BYTES = 16384;
    localparam int HIST_AW    = $clog2(CELL_BYTES);
    localparam int BIDX_W     = 17;   // saturating byte count, enough to rule out every copy

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_BADREF = 2'd2;

    localparam logic [7:0] LEN_MASK     = 8'h1F;
    localparam logic [7:0] PAT_LEN_MASK = 8'h07;
    localparam logic [3:0] PAT_ROW_MASK = 4'hE;

    // Color step after each pattern pixel, as an 8-bit two's complement addend.
    function automatic logic [7:0] pat_step(input logic [3:0] idx);
        logic [7:0] s;
        begin
            case (idx)
                4'd0:    s = 8'd0;
                4'd1:    s = 8'd1;
                4'd2:    s = 8'd1;
                4'd3:    s = 8'd1;
                4'd4:    s = 8'd2;
                4'd5:    s = 8'd2;
                4'd6:    s = 8'd3;
                4'd7:    s = 8'd3;
                4'd8:    s = 8'd0;
                4'd9:    s = 8'hFF;
                4'd10:   s = 8'hFF;
                4'd11:   s = 8'hFF;
                4'd12:   s = 8'hFE;
                4'd13:   s = 8'hFE;
                4'd14:   s = 8'hFD;
                default: s = 8'hFD;
            endcase
            return s;
        end
    endfunction

endpackage

FILE: rtl/core/sprite_cell_run_length_decoder_unit.sv
// ----------------------------------------------------------------------------
// sprite_cell_run_length_decoder_unit: compressed sprite cell decoder
// Parses a byte stream of sprite cells and emits origin-shifted pixels.
// ----------------------------------------------------------------------------
// One request is one cell byte. The byte is parsed in the cycle it is taken;
// bytes that draw pixels then hand a small sequencer a count, and the shared
// emit unit (one x adder, one color adder, one history read port) produces one
// result per cycle while out_stall is low. A back-copy first passes through
// a priming state (S_PREP) for the history read; the worst case is a 35-pixel
// copy plus finish mark. in_stall stays high until the last result of the
// byte is in the output register; that register lets the next byte be taken
// while the last result still waits downstream. The history store has no
// reset: every entry a copy may read lies below the byte count and was
// written in this cell. Origin registers are written on the cfg channel,
// which is always ready.
// ----------------------------------------------------------------------------
module sprite_cell_run_length_decoder_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               cell_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic signed [18:0] pos_x,
    output logic signed [18:0] pos_y,
    output logic [7:0]         color_first,
    output logic [7:0]         color_second,
    output logic               pair,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_EMIT} state_t;
    typedef enum logic [3:0] {
        PH_HEADER, PH_LINE_LEN, PH_LINE_SKIP, PH_LEAD, PH_OPCODE, PH_LITERAL,
        PH_RUN, PH_COPY_LO, PH_COPY_HI, PH_PAIR_A, PH_PAIR_B, PH_PATTERN, PH_DONE
    } phase_t;
    typedef enum logic [2:0] {M_LIT, M_RUN, M_COPY, M_PAIR, M_PAT} mode_t;

    localparam logic [7:0] CFG_ORIGIN_X = 8'd0;
    localparam logic [7:0] CFG_ORIGIN_Y = 8'd1;
    localparam int         AW = scrld_pkg::HIST_AW;
    localparam int         BW = scrld_pkg::BIDX_W;

    // history store
    logic [7:0]    hist_mem [scrld_pkg::CELL_BYTES];
    logic [7:0]    hist_q_reg;
    logic [AW-1:0] rd_addr;

    // parser state
    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [BW-1:0] bidx_reg, bidx_next;
    logic [15:0]   left_reg, left_next, top_reg, top_next, rows_reg, rows_next;
    logic [17:0]   row_reg, row_next, col_reg, col_next;
    logic [7:0]    lbytes_reg, lbytes_next;
    logic [8:0]    lcount_reg, lcount_next;
    logic [7:0]    opc_reg, opc_next;
    logic [15:0]   opnd_reg, opnd_next;
    logic signed [15:0] ox_reg, oy_reg;

    // emit sequencer
    mode_t              mode_reg, mode_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               fin_reg, fin_next;
    logic [7:0]         ca_reg, ca_next, cb_reg, cb_next;
    logic [1:0]         xstep_reg, xstep_next;
    logic               par_reg, par_next;
    logic signed [18:0] ref_reg, ref_next;
    logic [BW-1:0]      dp_reg, dp_next;
    logic [17:0]        prow_reg, prow_next;

    // output register
    logic               ov_reg, ov_next;
    logic [1:0]         kind_reg, kind_next;
    logic signed [18:0] px_reg, px_next, py_reg, py_next;
    logic [7:0]         c1_reg, c1_next, c2_reg, c2_next;
    logic               pair_reg, pair_next, last_reg, last_next;

    logic          accept, out_free, advance, ref_ok, hist_we;
    logic [BW-1:0] bi, dp_cur;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !ov_reg || !out_stall;
    assign advance  = (state_reg == S_EMIT) && out_free && (cnt_reg != 6'd0);
    assign bi       = cell_start ? '0 : bidx_reg;
    assign dp_cur   = (&bi) ? bi : bi + 1'b1;
    assign hist_we  = accept && (cell_start || phase_reg != PH_DONE)
                      && (bi < BW'(scrld_pkg::CELL_BYTES));

    // Prefetch the entry for the pixel that goes out next.
    assign rd_addr = advance ? AW'(ref_reg + 19'sd1) : AW'(ref_reg);
    assign ref_ok  = !ref_reg[18] && (ref_reg < $signed({2'b00, dp_reg}))
                     && (ref_reg < 19'(scrld_pkg::CELL_BYTES));

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[bi[AW-1:0]] <= data_byte;
        end
        hist_q_reg <= hist_mem[rd_addr];
    end

    always_comb
    begin
        logic [7:0]  b;
        logic        end_chk, do_adv;
        logic [8:0]  adv_inc;
        logic [17:0] rn;
        logic [17:0] xo;

        b = data_byte;
        end_chk = 1'b0;
        do_adv  = 1'b0;
        adv_inc = 9'd1;
        rn = '0;
        xo = '0;

        state_next  = state_reg;
        phase_next  = phase_reg;
        bidx_next   = bidx_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        rows_next   = rows_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        lbytes_next = lbytes_reg;
        lcount_next = lcount_reg;
        opc_next    = opc_reg;
        opnd_next   = opnd_reg;
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        ca_next     = ca_reg;
        cb_next     = cb_reg;
        xstep_next  = xstep_reg;
        par_next    = par_reg;
        ref_next    = ref_reg;
        dp_next     = dp_reg;
        prow_next   = prow_reg;

        ov_next   = ov_reg && out_stall;
        kind_next = kind_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        c1_next   = c1_reg;
        c2_next   = c2_reg;
        pair_next = pair_reg;
        last_next = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cell_start || phase_reg != PH_DONE))
                begin
                    phase_next = cell_start ? PH_HEADER : phase_reg;
                    bidx_next  = dp_cur;
                    prow_next  = row_reg;
                    cnt_next   = '0;
                    fin_next   = 1'b0;
                    xstep_next = 2'd1;
                    par_next   = 1'b0;
                    case (phase_next)
                        PH_HEADER:
                        begin
                            case (bi[2:0])
                                3'd0: left_next = {8'd0, b};
                                3'd1: left_next = {b, left_reg[7:0]};
                                3'd4: top_next  = {8'd0, b};
                                3'd5: top_next  = {b, top_reg[7:0]};
                                3'd6: rows_next = {8'd0, b};
                                3'd7:
                                begin
                                    rows_next = {b, rows_reg[7:0]};
                                    row_next  = {2'b00, top_reg};
                                    if (rows_next == 16'd0)
                                    begin
                                        fin_next   = 1'b1;
                                        phase_next = PH_DONE;
                                    end
                                    else
                                    begin
                                        phase_next = PH_LINE_LEN;
                                    end
                                end
                                default: ;
                            endcase
                            // only the first eight bytes count as header
                            if (bi > BW'(7))
                            begin
                                left_next  = left_reg;
                                top_next   = top_reg;
                                rows_next  = rows_reg;
                                row_next   = row_reg;
                                fin_next   = 1'b0;
                                phase_next = PH_HEADER;
                            end
                        end
                        PH_LINE_LEN:
                        begin
                            lbytes_next = b;
                            lcount_next = '0;
                            phase_next  = (b != 8'd0) ? PH_LEAD : PH_LINE_SKIP;
                        end
                        PH_LINE_SKIP:
                        begin
                            do_adv  = 1'b1;
                            adv_inc = {1'b0, b} + 9'd1;
                        end
                        PH_LEAD:
                        begin
                            col_next    = {2'b00, left_reg} + {10'd0, b};
                            lcount_next = 9'd1;
                            end_chk     = 1'b1;
                        end
                        PH_OPCODE:
                        begin
                            opc_next    = b;
                            lcount_next = lcount_reg + 9'd1;
                            case (b[7:5])
                                3'd0, 3'd1:
                                begin
                                    opnd_next  = {8'd0, b} + 16'd1;
                                    phase_next = PH_LITERAL;
                                end
                                3'd2: phase_next = PH_RUN;
                                3'd3: phase_next = PH_COPY_LO;
                                3'd4: phase_next = PH_PAIR_A;
                                3'd5:
                                begin
                                    col_next = col_reg + {13'd0, b[4:0]} + 18'd1;
                                    end_chk  = 1'b1;
                                end
                                default: phase_next = PH_PATTERN;
                            endcase
                        end
                        PH_LITERAL:
                        begin
                            lcount_next = lcount_reg + 9'd1;
                            mode_next   = M_LIT;
                            cnt_next    = 6'd1;
                            ca_next     = b;
                            opnd_next   = opnd_reg - 16'd1;
                            end_chk     = (opnd_next == 16'd0);
                        end
                        PH_RUN:
                        begin
                            lcount_next = lcount_reg + 9'd1;
                            mode_next   = M_RUN;
                            cnt_next    = {1'b0, opc_reg[4:0]} + 6'd3;
                            ca_next     = b;
                            end_chk     = 1'b1;
                        end
                        PH_COPY_LO:
                        begin
                            lcount_next = lcount_reg + 9'd1;
                            opnd_next   = {8'd0, b};
                            phase_next  = PH_COPY_HI;
                        end
                        PH_COPY_HI:
                        begin
                            lcount_next = lcount_reg + 9'd1;
                            opnd_next   = {b, opnd_reg[7:0]};
                            mode_next   = M_COPY;
                            cnt_next    = {1'b0, opc_reg[4:0]} + 6'd4;
                            dp_next     = dp_cur;
                            ref_next    = $signed({2'b00, dp_cur})
                                          - $signed({3'b000, opnd_next});
                            end_chk     = 1'b1;
                        end
                        PH_PAIR_A:
                        begin
                            lcount_next = lcount_reg + 9'd1;
                            opnd_next   = {8'd0, b};
                            phase_next  = PH_PAIR_B;
                        end
                        PH_PAIR_B:
                        begin
                            lcount_next = lcount_reg + 9'd1;
                            mode_next   = M_PAIR;
                            cnt_next    = {1'b0, opc_reg[4:0]} + 6'd2;
                            ca_next     = opnd_reg[7:0];
                            cb_next     = b;
                            xstep_next  = 2'd2;
                            end_chk     = 1'b1;
                        end
                        PH_PATTERN:
                        begin
                            lcount_next = lcount_reg + 9'd1;
                            mode_next   = M_PAT;
                            cnt_next    = {3'd0, opc_reg[2:0]} + 6'd3;
                            ca_next     = b;
                            end_chk     = 1'b1;
                        end
                        default: phase_next = PH_DONE;
                    endcase

                    // close the operand group: new line or next opcode
                    if (end_chk)
                    begin
                        if (lcount_next >= {1'b0, lbytes_next})
                        begin
                            do_adv = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_OPCODE;
                        end
                    end
                    if (do_adv)
                    begin
                        rn       = row_reg + {9'd0, adv_inc};
                        row_next = rn;
                        if (rn >= {1'b0, {1'b0, top_reg} + {1'b0, rows_reg}})
                        begin
                            fin_next   = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_LINE_LEN;
                        end
                    end

                    if (cnt_next != 6'd0 || fin_next)
                    begin
                        state_next = (mode_next == M_COPY && cnt_next != 6'd0)
                                     ? S_PREP : S_EMIT;
                    end
                end
            end
            S_PREP:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    if (cnt_reg != 6'd0)
                    begin
                        // pixel or pair at the running x
                        xo        = col_reg;
                        kind_next = scrld_pkg::KIND_PIXEL;
                        px_next   = $signed({1'b0, xo}) + 19'(ox_reg);
                        py_next   = $signed({1'b0, prow_reg}) + 19'(oy_reg);
                        c1_next   = ca_reg;
                        c2_next   = 8'd0;
                        pair_next = 1'b0;
                        last_next = (cnt_reg == 6'd1) && !fin_reg;
                        case (mode_reg)
                            M_COPY:
                            begin
                                if (ref_ok)
                                begin
                                    c1_next = hist_q_reg;
                                end
                                else
                                begin
                                    kind_next = scrld_pkg::KIND_BADREF;
                                    c1_next   = 8'd0;
                                end
                            end
                            M_PAIR:
                            begin
                                c2_next   = cb_reg;
                                pair_next = 1'b1;
                            end
                            M_PAT:
                            begin
                                ca_next = ca_reg + scrld_pkg::pat_step(
                                    (opc_reg[5:2] & scrld_pkg::PAT_ROW_MASK)
                                    | {3'd0, par_reg});
                            end
                            default: ;
                        endcase
                        par_next = !par_reg;
                        col_next = col_reg + {16'd0, xstep_reg};
                        ref_next = ref_reg + 19'sd1;
                        cnt_next = cnt_reg - 6'd1;
                        if (cnt_reg == 6'd1 && !fin_reg)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        // finish mark: every field but kind and last is zero
                        kind_next  = scrld_pkg::KIND_FINISH;
                        px_next    = '0;
                        py_next    = '0;
                        c1_next    = 8'd0;
                        c2_next    = 8'd0;
                        pair_next  = 1'b0;
                        last_next  = 1'b1;
                        fin_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_HEADER;
            bidx_reg   <= '0;
            left_reg   <= '0;
            top_reg    <= '0;
            rows_reg   <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            lbytes_reg <= '0;
            lcount_reg <= '0;
            opc_reg    <= '0;
            opnd_reg   <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            bidx_reg   <= bidx_next;
            left_reg   <= left_next;
            top_reg    <= top_next;
            rows_reg   <= rows_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            lbytes_reg <= lbytes_next;
            lcount_reg <= lcount_next;
            opc_reg    <= opc_next;
            opnd_reg   <= opnd_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            ov_reg     <= ov_next;
            if (cfg_valid && cfg_index == CFG_ORIGIN_X)
            begin
                ox_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_ORIGIN_Y)
            begin
                oy_reg <= cfg_data;
            end
        end
    end

    // datapath registers of the emit unit and the output stage
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        ca_reg    <= ca_next;
        cb_reg    <= cb_next;
        xstep_reg <= xstep_next;
        par_reg   <= par_next;
        ref_reg   <= ref_next;
        dp_reg    <= dp_next;
        prow_reg  <= prow_next;
        kind_reg  <= kind_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        c1_reg    <= c1_next;
        c2_reg    <= c2_next;
        pair_reg  <= pair_next;
        last_reg  <= last_next;
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = ov_reg;
    assign kind         = kind_reg;
    assign pos_x        = px_reg;
    assign pos_y        = py_reg;
    assign color_first  = c1_reg;
    assign color_second = c2_reg;
    assign pair         = pair_reg;
    assign last         = last_reg;

    // the sequencer never goes idle with results left to emit
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cnt_reg == 6'd0 && !fin_reg))
        else $error("idle with pending results");

    // a finish mark always closes the results of its byte
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == scrld_pkg::KIND_FINISH) |-> (last && !pair))
        else $error("finish mark without last");

    // pairs come only from valid pixel results
    a_pair_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pair) |-> (kind == scrld_pkg::KIND_PIXEL))
        else $error("pair on non-pixel result");

    // a copy read is always primed before its first pixel
    a_prep_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP) |=> (state_reg == S_EMIT))
        else $error("prime cycle not followed by emit");

endmodule
